// ----- sv/lppm_pkg.sv -----
// shared constants, types and sine table builder for the pulse pattern modulator
package lppm_pkg;

  // channel and rate limits
  localparam int unsigned Channels     = 8;
  localparam int unsigned LineW        = $clog2(Channels);
  localparam int unsigned MaskW        = 8;
  localparam int unsigned MaxRate      = 100000;
  localparam int unsigned RateW        = 17;
  localparam int unsigned DutyW        = 16;
  localparam int unsigned TimerW       = 32;

  // sine table geometry
  localparam int unsigned SineEntries    = 1024;
  localparam int unsigned SineIdxW       = $clog2(SineEntries);
  localparam int unsigned QuarterEntries = SineEntries / 4;
  localparam int unsigned QIdxW          = SineIdxW - 1;

  // phase scale 2^64/(40000*pi), split into a 32-bit low part and a 16-bit high part
  localparam logic [63:0] PhaseK   = 64'd146794525164093;
  localparam logic [31:0] PhaseK0  = PhaseK[31:0];
  localparam logic [15:0] PhaseK1  = PhaseK[47:32];

  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] OneQ30    = 64'd1073741824;

  // input action codes
  typedef enum logic [1:0] {
    ActTick = 2'd0,
    ActMode = 2'd1,
    ActRate = 2'd2
  } action_e;

  // channel pattern modes
  typedef enum logic [1:0] {
    ModeAll    = 2'd0,
    ModeSingle = 2'd1,
    ModeOdd    = 2'd2,
    ModeEven   = 2'd3
  } mode_e;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone   = 4'd0,
    OpTick   = 4'd1,
    OpButton = 4'd2,
    OpMulLo  = 4'd3,
    OpMulMid = 4'd4,
    OpMulHi  = 4'd5,
    OpRom    = 4'd6,
    OpDuty   = 4'd7,
    OpLoad   = 4'd8
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef logic [QuarterEntries:0][14:0] qrom_t;

  // quarter wave magnitude in q15, odd taylor series to degree 11 in q30
  function automatic logic [14:0] sin_quarter_q15(input int unsigned g);
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] acc;
    logic [63:0] r;
    t   = (64'(g) * HalfPiQ30) / 64'(SineEntries);
    t2  = (t * t) >> 30;
    acc = OneQ30;
    acc = OneQ30 - ((t2 * acc) >> 30) / 64'd110;
    acc = OneQ30 - ((t2 * acc) >> 30) / 64'd72;
    acc = OneQ30 - ((t2 * acc) >> 30) / 64'd42;
    acc = OneQ30 - ((t2 * acc) >> 30) / 64'd20;
    acc = OneQ30 - ((t2 * acc) >> 30) / 64'd6;
    r   = (t * acc) >> 30;
    r   = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

  // quarter wave table, one entry per table step from zero to a quarter turn
  function automatic qrom_t build_qrom();
    qrom_t rom;
    for (int q = 0; q <= int'(QuarterEntries); q++) begin
      rom[q] = sin_quarter_q15(unsigned'(q * 4));
    end
    return rom;
  endfunction

endpackage

// ----- sv/lppm_ctrl.sv -----
// sequencing controller: accepts items, steps the datapath, owns result valid
module lppm_ctrl
  import lppm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    is_tick_i,
  input  logic    out_stall_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMulLo,
    StMulMid,
    StMulHi,
    StRom,
    StDuty,
    StHold
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and datapath command
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = OpNone;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (is_tick_i) begin
            cmd_o.op = OpTick;
            state_d  = StMulLo;
          end else begin
            cmd_o.op = OpButton;
            state_d  = StHold;
          end
        end
      end
      StMulLo: begin
        cmd_o.op = OpMulLo;
        state_d  = StMulMid;
      end
      StMulMid: begin
        cmd_o.op = OpMulMid;
        state_d  = StMulHi;
      end
      StMulHi: begin
        cmd_o.op = OpMulHi;
        state_d  = StRom;
      end
      StRom: begin
        cmd_o.op = OpRom;
        state_d  = StDuty;
      end
      StDuty: begin
        cmd_o.op = OpDuty;
        state_d  = StHold;
      end
      StHold: begin
        if (out_free) begin
          cmd_o.op    = OpLoad;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

endmodule

// ----- sv/lppm_datapath.sv -----
// datapath: mode and rate state, shared multiplier, sine rom, result register
module lppm_datapath
  import lppm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [1:0]          action_i,
  input  logic [TimerW-1:0]   timer_value_i,
  input  logic                button_changed_i,
  input  logic                cfg_we_i,
  input  logic [DutyW-1:0]    cfg_wdata_i,
  output logic [DutyW-1:0]    duty_o,
  output logic [MaskW-1:0]    channel_mask_o,
  output logic [1:0]          mode_now_o,
  output logic [RateW-1:0]    pulse_rate_o,
  output logic                timer_run_o
);

  localparam qrom_t QuarterRom = build_qrom();

  // control state
  mode_e              mode_q, mode_d;
  logic [LineW-1:0]   line_q, line_d;
  logic [RateW-1:0]   rate_q, rate_d;
  logic               timer_on_q, timer_on_d;
  logic [DutyW-1:0]   max_duty_q;
  logic               is_tick_q;

  // work registers
  logic [48:0]        p1_q;
  logic [31:0]        phase_q;
  logic [1:0]         quad_q;
  logic [14:0]        mag_q;
  logic [DutyW-1:0]   duty_q;

  // result register
  logic [DutyW-1:0]   out_duty_q;
  logic [MaskW-1:0]   out_mask_q;
  logic [1:0]         out_mode_q;
  logic [RateW-1:0]   out_rate_q;
  logic               out_timer_q;

  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          prod;
  logic [SineIdxW-1:0]  sidx;
  logic [SineIdxW-3:0]  sfrac;
  logic [QIdxW-1:0]     qidx;
  logic [DutyW-1:0]     offset_sine;
  logic [LineW:0]       line_inc;
  logic [MaskW-1:0]     mask;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OpTick: begin
        mul_a = {{(32-RateW){1'b0}}, rate_q};
        mul_b = timer_value_i;
      end
      OpMulLo: begin
        mul_a = p1_q[31:0];
        mul_b = PhaseK0;
      end
      OpMulMid: begin
        mul_a = p1_q[31:0];
        mul_b = {16'd0, PhaseK1};
      end
      OpMulHi: begin
        mul_a = {15'd0, p1_q[48:32]};
        mul_b = PhaseK0;
      end
      OpDuty: begin
        mul_a = {16'd0, max_duty_q};
        mul_b = {16'd0, offset_sine};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  // sine table address from the top phase bits, folded to a quarter wave
  assign sidx  = phase_q[31 -: SineIdxW];
  assign sfrac = sidx[SineIdxW-3:0];
  assign qidx  = sidx[SineIdxW-2] ? (QIdxW'(QuarterEntries) - {1'b0, sfrac})
                                  : {1'b0, sfrac};

  // signed sine plus half scale, as unsigned
  assign offset_sine = quad_q[1] ? (16'h8000 - {1'b0, mag_q})
                                 : (16'h8000 + {1'b0, mag_q});

  // channel pattern for the current mode
  always_comb begin
    mask = '0;
    for (int i = 0; i < int'(MaskW); i++) begin
      if (i < int'(Channels)) begin
        case (mode_q)
          ModeAll:    mask[i] = 1'b1;
          ModeSingle: mask[i] = (line_q == LineW'(i));
          ModeOdd:    mask[i] = (i % 2) == 1;
          default:    mask[i] = (i % 2) == 0;
        endcase
      end
    end
  end

  // button handling
  assign line_inc = {1'b0, line_q} + 1'b1;

  always_comb begin
    mode_d     = mode_q;
    line_d     = line_q;
    rate_d     = rate_q;
    timer_on_d = timer_on_q;
    if (button_changed_i && action_i == ActMode) begin
      case (mode_q)
        ModeAll: begin
          mode_d = ModeSingle;
        end
        ModeSingle: begin
          if (line_inc >= (LineW+1)'(Channels)) begin
            line_d = '0;
            mode_d = ModeOdd;
          end else begin
            line_d = line_inc[LineW-1:0];
          end
        end
        ModeOdd: begin
          mode_d = ModeEven;
        end
        default: begin
          mode_d = ModeAll;
        end
      endcase
    end else if (button_changed_i && action_i == ActRate) begin
      if (rate_q >= RateW'(MaxRate)) begin
        rate_d     = '0;
        timer_on_d = 1'b0;
      end else begin
        rate_d     = rate_q + 1'b1;
        timer_on_d = 1'b1;
      end
    end
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeAll;
      line_q     <= '0;
      rate_q     <= '0;
      timer_on_q <= 1'b1;
      max_duty_q <= '1;
      is_tick_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_duty_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OpTick) begin
        is_tick_q <= 1'b1;
      end
      if (cmd_i.op == OpButton) begin
        is_tick_q  <= 1'b0;
        mode_q     <= mode_d;
        line_q     <= line_d;
        rate_q     <= rate_d;
        timer_on_q <= timer_on_d;
      end
    end
  end

  // work and result registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OpTick: begin
        p1_q <= prod[48:0];
      end
      OpMulLo: begin
        phase_q <= prod[63:32];
      end
      OpMulMid, OpMulHi: begin
        phase_q <= phase_q + prod[31:0];
      end
      OpRom: begin
        quad_q <= sidx[SineIdxW-1 -: 2];
        mag_q  <= QuarterRom[qidx];
      end
      OpDuty: begin
        duty_q <= prod[31:16];
      end
      OpLoad: begin
        out_duty_q  <= is_tick_q ? duty_q : '0;
        out_mask_q  <= is_tick_q ? mask : '0;
        out_mode_q  <= mode_q;
        out_rate_q  <= rate_q;
        out_timer_q <= timer_on_q;
      end
      OpNone, OpButton: begin
      end
      default: begin
      end
    endcase
  end

  assign duty_o         = out_duty_q;
  assign channel_mask_o = out_mask_q;
  assign mode_now_o     = out_mode_q;
  assign pulse_rate_o   = out_rate_q;
  assign timer_run_o    = out_timer_q;

endmodule

// ----- sv/led_pulse_pattern_modulator_core.sv -----
// top level of the breathing led pulse pattern modulator
// A tick transfer runs through the states MulLo, MulMid, MulHi, Rom, Duty and
// Hold until its result is in the output register: one 32x32 multiplier is
// shared over five steps (rate times timer, three partial products of the phase
// scale, and the duty scaling) with the registered sine rom read in between; a
// button transfer goes through Hold only. A new item is taken once the previous
// result has been loaded into the output register, which holds it under stall,
// so an item is never taken while another is in flight. max_duty may be written
// via cfg_we_i whenever no item is in flight.
module led_pulse_pattern_modulator_core
  import lppm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [DutyW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic [TimerW-1:0]   timer_value_i,
  input  logic                button_changed_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [DutyW-1:0]    duty_o,
  output logic [MaskW-1:0]    channel_mask_o,
  output logic [1:0]          mode_now_o,
  output logic [RateW-1:0]    pulse_rate_o,
  output logic                timer_run_o
);

  dp_cmd_t cmd;
  logic    is_tick;

  assign is_tick = (action_i == ActTick);

  // sequencing
  lppm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_tick_i   (is_tick),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  lppm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (action_i),
    .timer_value_i    (timer_value_i),
    .button_changed_i (button_changed_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .duty_o           (duty_o),
    .channel_mask_o   (channel_mask_o),
    .mode_now_o       (mode_now_o),
    .pulse_rate_o     (pulse_rate_o),
    .timer_run_o      (timer_run_o)
  );

  // busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous item still in flight");

  // rate never exceeds its maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pulse_rate_o <= RateW'(MaxRate))
    else $error("pulse rate above maximum");

  // a stopped timer only follows a rate wrap to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !timer_run_o |-> pulse_rate_o == '0)
    else $error("timer stopped with nonzero rate");

  // single line mode lights at most one channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_now_o == ModeSingle |-> $onehot0(channel_mask_o))
    else $error("single line mode with several channels on");

endmodule
